@@ rtl/idcp_pkg.sv @@
// Shared types, status and sequence codes, and port tables for the ISA DMA
// channel programmer. No dependencies.
package idcp_pkg;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_CHANNEL = 3'd1;
   localparam logic [2:0] ST_ZERO    = 3'd2;
   localparam logic [2:0] ST_ALIGN   = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;
   localparam logic [2:0] ST_WINDOW  = 3'd5;

   localparam logic [2:0] CASCADE_CHANNEL = 3'd4;

   // Position of a word within the nine-word programming sequence
   localparam logic [3:0] BEAT_MASK     = 4'd0;
   localparam logic [3:0] BEAT_CLEAR    = 4'd1;
   localparam logic [3:0] BEAT_MODE     = 4'd2;
   localparam logic [3:0] BEAT_PAGE     = 4'd3;
   localparam logic [3:0] BEAT_ADDR_LO  = 4'd4;
   localparam logic [3:0] BEAT_ADDR_HI  = 4'd5;
   localparam logic [3:0] BEAT_COUNT_LO = 4'd6;
   localparam logic [3:0] BEAT_COUNT_HI = 4'd7;
   localparam logic [3:0] BEAT_UNMASK   = 4'd8;

   localparam logic [7:0] MASK_PORT_8   = 8'h0A;
   localparam logic [7:0] MASK_PORT_16  = 8'hD4;
   localparam logic [7:0] CLEAR_PORT_8  = 8'h0C;
   localparam logic [7:0] CLEAR_PORT_16 = 8'hD8;
   localparam logic [7:0] MODE_PORT_8   = 8'h0B;
   localparam logic [7:0] MODE_PORT_16  = 8'hD6;
   localparam logic [7:0] MASK_SET_BIT  = 8'h04;

   typedef struct packed {
      logic [2:0]  status;
      logic        wide;
      logic [2:0]  channel;
      logic [7:0]  mode_byte;
      logic [7:0]  page;
      logic [15:0] offset;
      logic [15:0] count;
   } idcp_plan_type;

   typedef struct packed {
      logic [7:0] port_number;
      logic [7:0] port_data;
      logic [2:0] status;
      logic       last;
   } idcp_word_type;

   function automatic logic [7:0] page_reg_of(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0:    p = 8'h87;
         3'd1:    p = 8'h83;
         3'd2:    p = 8'h81;
         3'd3:    p = 8'h82;
         3'd4:    p = 8'h8F;
         3'd5:    p = 8'h8B;
         3'd6:    p = 8'h89;
         3'd7:    p = 8'h8A;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] addr_reg_of(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0:    p = 8'h00;
         3'd1:    p = 8'h02;
         3'd2:    p = 8'h04;
         3'd3:    p = 8'h06;
         3'd4:    p = 8'hC0;
         3'd5:    p = 8'hC4;
         3'd6:    p = 8'hC8;
         3'd7:    p = 8'hCC;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] count_reg_of(input logic [2:0] ch);
      logic [7:0] p;
      case (ch)
         3'd0:    p = 8'h01;
         3'd1:    p = 8'h03;
         3'd2:    p = 8'h05;
         3'd3:    p = 8'h07;
         3'd4:    p = 8'hC2;
         3'd5:    p = 8'hC6;
         3'd6:    p = 8'hCA;
         3'd7:    p = 8'hCE;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

@@ rtl/idcp_if.sv @@
// Valid/ready channel interfaces for requests and port-write words.
// Depends on nothing.
interface idcp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  mode_byte;
   logic [2:0]  channel;
   logic [31:0] phys_address;
   logic [31:0] byte_count;

   modport source (output valid, mode_byte, channel, phys_address, byte_count,
                   input ready);
   modport sink (input valid, mode_byte, channel, phys_address, byte_count,
                 output ready);
endinterface

interface idcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] port_number;
   logic [7:0] port_data;
   logic [2:0] status;
   logic       last;

   modport source (output valid, port_number, port_data, status, last,
                   input ready);
   modport sink (input valid, port_number, port_data, status, last,
                 output ready);
endinterface

@@ rtl/isa_dma_channel_programmer_unit.sv @@
// An accepted request is first registered, and its first port-write word is
// then registered into the result register; an accepted request gives
// nine words, one per cycle while the receiver is ready, and a rejected one
// gives a single status word. The word sequencer holds one request at a
// time; the next request is taken while the last word is loaded.
// Reset clears the request and result valid flags and the beat counter.
module isa_dma_channel_programmer_unit
   import idcp_pkg::*;
#(
   parameter int ADDRESS_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   idcp_req_if.sink    req_ch,
   idcp_rsp_if.source  rsp_ch
);

   logic          req_valid_ff, req_valid_in;
   logic [7:0]    mode_ff;
   logic [2:0]    channel_ff;
   logic [31:0]   address_ff;
   logic [31:0]   count_ff;
   logic          accept;
   logic          item_done;
   idcp_plan_type plan;
   idcp_word_type word;

   assign req_ch.ready = !req_valid_ff || item_done;
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_valid_in = accept ? 1'b1 : (item_done ? 1'b0 : req_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   // hold the request until its last word is loaded
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_ch.mode_byte;
         channel_ff <= req_ch.channel;
         address_ff <= req_ch.phys_address;
         count_ff   <= req_ch.byte_count;
      end
   end

   idcp_check #(
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_check (
      .mode_byte    (mode_ff),
      .channel      (channel_ff),
      .phys_address (address_ff),
      .byte_count   (count_ff),
      .plan         (plan)
   );

   idcp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .plan       (plan),
      .item_done  (item_done),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_word   (word)
   );

   assign rsp_ch.port_number = word.port_number;
   assign rsp_ch.port_data   = word.port_data;
   assign rsp_ch.status      = word.status;
   assign rsp_ch.last        = word.last;

   a_done_needs_item: assert property (@(posedge clock) disable iff (reset)
      item_done |-> req_valid_ff)
      else $error("sequence finished with no request held");

   a_held_request_stable: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !item_done |=> $stable(address_ff) && $stable(count_ff))
      else $error("held request changed mid-sequence");

   a_refill_after_done: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !item_done |-> !req_ch.ready)
      else $error("request taken while previous one still in sequence");

endmodule

@@ rtl/idcp_check.sv @@
// Request checker: status of the first failing check plus the page, offset
// and count fields of the sequence. Depends on idcp_pkg.
module idcp_check
   import idcp_pkg::*;
#(
   parameter int ADDRESS_BITS = 24
) (
   input  logic [7:0]    mode_byte,
   input  logic [2:0]    channel,
   input  logic [31:0]   phys_address,
   input  logic [31:0]   byte_count,
   output idcp_plan_type plan
);

   localparam logic [32:0] LIMIT = 33'd1 << ADDRESS_BITS;

   logic        wide;
   logic [16:0] win_mask;
   logic [32:0] win_size;
   logic [32:0] end_sum;
   logic [32:0] win_end;
   logic        above_limit;
   logic [15:0] units;

   assign wide        = (channel > CASCADE_CHANNEL);
   assign win_mask    = wide ? 17'h1FFFF : 17'h0FFFF;
   assign win_size    = wide ? 33'h20000 : 33'h10000;
   assign end_sum     = {1'b0, phys_address} + {1'b0, byte_count};
   assign win_end     = {16'd0, phys_address[16:0] & win_mask} + {1'b0, byte_count};
   assign above_limit = ({1'b0, phys_address} >= LIMIT) || (end_sum > LIMIT);
   assign units       = wide ? byte_count[16:1] : byte_count[15:0];

   always_comb begin
      if (channel == CASCADE_CHANNEL) begin
         plan.status = ST_CHANNEL;
      end else if (byte_count == 32'd0) begin
         plan.status = ST_ZERO;
      end else if (wide && (phys_address[0] || byte_count[0])) begin
         plan.status = ST_ALIGN;
      end else if (above_limit) begin
         plan.status = ST_RANGE;
      end else if (win_end > win_size) begin
         plan.status = ST_WINDOW;
      end else begin
         plan.status = ST_OK;
      end
      plan.wide      = wide;
      plan.channel   = channel;
      plan.mode_byte = mode_byte;
      plan.page      = phys_address[23:16];
      plan.offset    = wide ? phys_address[16:1] : phys_address[15:0];
      plan.count     = units - 16'd1;
   end

endmodule

@@ rtl/idcp_seq.sv @@
// Word sequencer: walks the nine port writes of a checked request into the
// result register, or emits one rejection word. Depends on idcp_pkg.
module idcp_seq
   import idcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  idcp_plan_type plan,
   output logic          item_done,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output idcp_word_type rsp_word
);

   logic [3:0]    beat_ff, beat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   idcp_word_type word_ff, word_in;
   logic          load;
   logic          reject;
   logic [7:0]    low2;

   assign load      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign reject    = (plan.status != ST_OK);
   assign item_done = load && (reject || (beat_ff == BEAT_UNMASK));
   assign low2      = {6'd0, plan.channel[1:0]};

   always_comb begin
      word_in.status = plan.status;
      word_in.last   = reject || (beat_ff == BEAT_UNMASK);
      case (beat_ff)
         BEAT_MASK: begin
            word_in.port_number = plan.wide ? MASK_PORT_16 : MASK_PORT_8;
            word_in.port_data   = MASK_SET_BIT | low2;
         end
         BEAT_CLEAR: begin
            word_in.port_number = plan.wide ? CLEAR_PORT_16 : CLEAR_PORT_8;
            word_in.port_data   = 8'h00;
         end
         BEAT_MODE: begin
            word_in.port_number = plan.wide ? MODE_PORT_16 : MODE_PORT_8;
            word_in.port_data   = plan.mode_byte | low2;
         end
         BEAT_PAGE: begin
            word_in.port_number = page_reg_of(plan.channel);
            word_in.port_data   = plan.page;
         end
         BEAT_ADDR_LO: begin
            word_in.port_number = addr_reg_of(plan.channel);
            word_in.port_data   = plan.offset[7:0];
         end
         BEAT_ADDR_HI: begin
            word_in.port_number = addr_reg_of(plan.channel);
            word_in.port_data   = plan.offset[15:8];
         end
         BEAT_COUNT_LO: begin
            word_in.port_number = count_reg_of(plan.channel);
            word_in.port_data   = plan.count[7:0];
         end
         BEAT_COUNT_HI: begin
            word_in.port_number = count_reg_of(plan.channel);
            word_in.port_data   = plan.count[15:8];
         end
         BEAT_UNMASK: begin
            word_in.port_number = plan.wide ? MASK_PORT_16 : MASK_PORT_8;
            word_in.port_data   = low2;
         end
         default: begin
            word_in.port_number = 8'h00;
            word_in.port_data   = 8'h00;
         end
      endcase
      // a rejection word carries only the status and the last flag
      if (reject) begin
         word_in.port_number = 8'h00;
         word_in.port_data   = 8'h00;
      end
   end

   always_comb begin
      beat_in = beat_ff;
      if (item_done) begin
         beat_in = BEAT_MASK;
      end else if (load) begin
         beat_in = beat_ff + 4'd1;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff      <= BEAT_MASK;
         rsp_valid_ff <= 1'b0;
      end else begin
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = word_ff;

   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      beat_ff <= BEAT_UNMASK)
      else $error("beat counter past the unmask word");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (word_ff.status != ST_OK) |->
         word_ff.last && (word_ff.port_number == 8'h00) && (word_ff.port_data == 8'h00))
      else $error("rejection word not a single zero word");

   a_reject_at_start: assert property (@(posedge clock) disable iff (reset)
      load && reject |-> beat_ff == BEAT_MASK)
      else $error("rejection seen in the middle of a sequence");

   a_beat_advance: assert property (@(posedge clock) disable iff (reset)
      load && !item_done |=> beat_ff == $past(beat_ff) + 4'd1)
      else $error("beat counter did not advance");

endmodule
